FILE: hdl/dmx_pkg.sv
package dmx_pkg;

    localparam int SenderSlots      = 8;
    localparam int Channels         = 512;
    localparam int PriorityChannels = 256;
    localparam int MsPerSecond      = 1000;

    typedef enum logic [1:0] {
        CMD_HEADER = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_EVAL   = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        MM_OFF      = 2'd0,
        MM_HTP      = 2'd1,
        MM_TAKEOVER = 2'd2,
        MM_PRIO_MAX = 2'd3
    } t_merge_mode;

    localparam logic [2:0] LossZero   = 3'd1;
    localparam logic [2:0] LossPreset = 3'd3;
    localparam logic [2:0] LossHome   = 3'd4;

    localparam logic [1:0] ActNone   = 2'd0;
    localparam logic [1:0] ActZero   = 2'd1;
    localparam logic [1:0] ActPreset = 2'd2;
    localparam logic [1:0] ActHome   = 2'd3;

    localparam logic [2:0] RegUniverse = 3'd0;
    localparam logic [2:0] RegMerge    = 3'd1;
    localparam logic [2:0] RegLoss     = 3'd2;
    localparam logic [2:0] RegFailsafe = 3'd3;
    localparam logic [2:0] RegDefault  = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PICK,
        ST_RDREQ,
        ST_RDWAIT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [1:0]  command;
        logic [2:0]  slot;
        logic        sender_active;
        logic [15:0] sender_universe;
        logic [7:0]  sender_priority;
        logic [31:0] time_ms;
        logic [9:0]  data_length;
        logic [8:0]  channel;
        logic [7:0]  value;
    } t_in_word;

    typedef struct packed {
        logic [7:0]  channel_value;
        logic        channel_written;
        logic        source_lost;
        logic [31:0] loss_count;
        logic [3:0]  contributor_count;
        logic [1:0]  loss_action;
    } t_out_word;

endpackage

FILE: hdl/dmx_source_merge_core.sv
// DMX source merge.
// Input channel: valid/ready words carrying a command. Header commands
// update the sender table and channel write commands the channel byte
// memory; neither gives a result word, and the input stays ready. Evaluate
// scans the sender slots one per cycle against the port universe and the
// timeout, then, unless no live sender is found, scans again to pick the
// winner. Read channel walks the slots through the channel byte memory
// (one read port, registered), a request state then a wait state per slot.
// Ready stays low from the accept of an evaluate or a read until its
// result is loaded, and the next word is accepted in the cycle after. A
// result word waits in the output register while the receiver stalls;
// writes go on meanwhile, and the next evaluate or read holds in its last
// state until the register is free, keeping ready low.
// Reset empties the sender table, the live set and the loss counter and
// loads register defaults. Channel bytes are not cleared; reading a byte
// never written gives an arbitrary value.
// Configuration: APB writes at 4*index, always ready, reads return values.
module dmx_source_merge_core #(
    parameter int SENDER_SLOTS      = dmx_pkg::SenderSlots,
    parameter int CHANNELS          = dmx_pkg::Channels,
    parameter int PRIORITY_CHANNELS = dmx_pkg::PriorityChannels
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  dmx_pkg::t_in_word i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output dmx_pkg::t_out_word o_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import dmx_pkg::*;

    localparam int SW = (SENDER_SLOTS > 1) ? $clog2(SENDER_SLOTS) : 1;
    localparam int AW = $clog2(SENDER_SLOTS * CHANNELS);
    localparam int CW = $clog2(SENDER_SLOTS + 1);

    // Configuration registers.
    logic [15:0] r_port_universe;
    logic [1:0]  r_merge_mode;
    logic [2:0]  r_loss_mode;
    logic [7:0]  r_failsafe;
    logic [15:0] r_default_ms;
    logic        cfg_we;
    logic [2:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_we  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_universe <= '0;
            r_merge_mode    <= '0;
            r_loss_mode     <= '0;
            r_failsafe      <= '0;
            r_default_ms    <= 16'd2500;
        end else if (cfg_we) begin
            case (cfg_idx)
                RegUniverse: r_port_universe <= pwdata[15:0];
                RegMerge:    r_merge_mode    <= pwdata[1:0];
                RegLoss:     r_loss_mode     <= pwdata[2:0];
                RegFailsafe: r_failsafe      <= pwdata[7:0];
                RegDefault:  r_default_ms    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            RegUniverse: prdata = {16'd0, r_port_universe};
            RegMerge:    prdata = {30'd0, r_merge_mode};
            RegLoss:     prdata = {29'd0, r_loss_mode};
            RegFailsafe: prdata = {24'd0, r_failsafe};
            RegDefault:  prdata = {16'd0, r_default_ms};
            default:     prdata = '0;
        endcase
    end

    // Sender table.
    logic [SENDER_SLOTS-1:0] r_active;
    logic [15:0] r_univ  [SENDER_SLOTS];
    logic [7:0]  r_prio  [SENDER_SLOTS];
    logic [31:0] r_ltime [SENDER_SLOTS];
    logic [9:0]  r_len   [SENDER_SLOTS];

    // Merge state.
    logic [SENDER_SLOTS-1:0] r_live, n_live;
    logic [7:0]  r_top, n_top;
    logic [SW-1:0] r_winner, n_winner;
    logic        r_lost, n_lost;
    logic [31:0] r_loss_cnt, n_loss_cnt;

    t_state      r_state, n_state;
    t_in_word    r_cmd;
    logic [SW:0] r_idx, n_idx;
    logic        r_have, n_have;
    logic [SW-1:0] r_best, n_best;
    logic [7:0]  r_acc, n_acc;
    logic        r_obuf_v, n_obuf_v;
    t_out_word   r_obuf, n_obuf;
    logic [1:0]  r_action, n_action;
    logic [31:0] r_fto;

    logic        in_acc;
    logic        slot_ok;
    logic        chan_ok;
    logic [SW-1:0] cur;
    logic [SW-1:0] wslot;

    assign o_ready = (r_state == ST_IDLE);
    assign in_acc  = i_valid && o_ready;
    assign o_valid = r_obuf_v;
    assign o_data  = r_obuf;
    assign cur     = r_idx[SW-1:0];
    assign wslot   = i_data.slot[SW-1:0];
    assign slot_ok = ({29'd0, i_data.slot} < 32'(SENDER_SLOTS));
    assign chan_ok = ({23'd0, i_data.channel} < 32'(CHANNELS));

    // Channel byte memory.
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_rdata;

    assign mem_we    = in_acc && (i_data.command == CMD_WRITE) && slot_ok && chan_ok;
    assign mem_waddr = AW'(32'(wslot) * 32'(CHANNELS) + 32'(i_data.channel));
    assign mem_raddr = AW'(32'(cur) * 32'(CHANNELS) + 32'(r_cmd.channel));

    dmx_chan_mem #(
        .SLOTS(SENDER_SLOTS),
        .CHANS(CHANNELS)
    ) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(i_data.value),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    // Header writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            for (int k = 0; k < SENDER_SLOTS; k++) begin
                r_univ[k]  <= '0;
                r_prio[k]  <= '0;
                r_ltime[k] <= '0;
                r_len[k]   <= '0;
            end
        end else if (in_acc && (i_data.command == CMD_HEADER) && slot_ok) begin
            r_active[wslot] <= i_data.sender_active;
            r_univ[wslot]   <= i_data.sender_universe;
            r_prio[wslot]   <= i_data.sender_priority;
            r_ltime[wslot]  <= i_data.time_ms;
            r_len[wslot]    <= i_data.data_length;
        end
    end

    // Timeout is captured at command accept; one multiply by a constant.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd <= i_data;
            r_fto <= (r_failsafe != 8'd0) ? 32'(r_failsafe) * 32'(MsPerSecond)
                                          : {16'd0, r_default_ms};
        end
    end

    // Shared per-slot test terms.
    logic [31:0] age;
    logic        slot_live;
    logic [31:0] elen;
    logic [31:0] lim;
    logic        is_top;
    logic        use_max;
    logic [CW-1:0] live_cnt;
    logic        last;

    assign age       = r_cmd.time_ms - r_ltime[cur];
    assign slot_live = r_active[cur] && (r_univ[cur] == r_port_universe) && (age < r_fto);
    assign elen      = (32'(r_len[cur]) > 32'(CHANNELS)) ? 32'(CHANNELS) : 32'(r_len[cur]);
    assign lim       = (r_merge_mode == MM_PRIO_MAX) ?
                       ((elen > 32'(PRIORITY_CHANNELS)) ? 32'(PRIORITY_CHANNELS) : elen) : elen;
    assign is_top    = r_prio[cur] >= r_top;
    assign last      = (r_idx == (SW+1)'(SENDER_SLOTS - 1));

    always_comb begin
        live_cnt = '0;
        for (int k = 0; k < SENDER_SLOTS; k++) begin
            live_cnt = live_cnt + CW'(r_live[k]);
        end
    end

    assign use_max = (r_merge_mode == MM_PRIO_MAX) ||
                     ((r_merge_mode == MM_HTP) && (live_cnt > CW'(1)));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && (i_data.command == CMD_EVAL)) begin
                    n_state = ST_SCAN;
                end else if (in_acc && (i_data.command == CMD_READ)) begin
                    n_state = ST_RDREQ;
                end
            end
            ST_SCAN:   n_state = last ? ST_PICK : ST_SCAN;
            ST_PICK:   n_state = last ? ST_OUT : ST_PICK;
            ST_RDREQ:  n_state = ST_RDWAIT;
            ST_RDWAIT: n_state = last ? ST_OUT : ST_RDREQ;
            ST_OUT:    n_state = (r_obuf_v && !i_ready) ? ST_OUT : ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        n_idx      = r_idx;
        n_live     = r_live;
        n_top      = r_top;
        n_winner   = r_winner;
        n_lost     = r_lost;
        n_loss_cnt = r_loss_cnt;
        n_have     = r_have;
        n_best     = r_best;
        n_acc      = r_acc;
        n_action   = r_action;
        n_obuf_v   = r_obuf_v;
        n_obuf     = r_obuf;
        if (r_obuf_v && i_ready) begin
            n_obuf_v = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                n_idx    = '0;
                n_have   = 1'b0;
                n_best   = '0;
                n_acc    = '0;
                n_action = ActNone;
                if (in_acc && (i_data.command == CMD_EVAL)) begin
                    n_live = '0;
                    n_top  = '0;
                end
            end
            ST_SCAN: begin
                if (slot_live) begin
                    n_live[cur] = 1'b1;
                    if (r_prio[cur] > r_top) begin
                        n_top = r_prio[cur];
                    end
                end
                if (last) begin
                    n_idx = '0;
                    if (n_live == '0) begin
                        if (!r_lost) begin
                            n_loss_cnt = r_loss_cnt + 32'd1;
                        end
                        n_lost   = 1'b1;
                        n_winner = '0;
                        n_idx    = (SW+1)'(SENDER_SLOTS - 1);
                        if (r_loss_mode == LossZero) begin
                            n_action = ActZero;
                        end else if (r_loss_mode == LossPreset) begin
                            n_action = ActPreset;
                        end else if (r_loss_mode == LossHome) begin
                            n_action = ActHome;
                        end
                    end else begin
                        n_lost = 1'b0;
                    end
                end else begin
                    n_idx = r_idx + (SW+1)'(1);
                end
            end
            ST_PICK: begin
                if (!r_lost && r_live[cur]) begin
                    if (r_merge_mode == MM_TAKEOVER) begin
                        if (!r_have || (r_prio[cur] > r_prio[r_best]) ||
                            ((r_prio[cur] == r_prio[r_best]) &&
                             (r_ltime[cur] > r_ltime[r_best]))) begin
                            n_best = cur;
                            n_have = 1'b1;
                        end
                    end else if ((r_merge_mode == MM_OFF) || is_top) begin
                        if (!r_have || (r_ltime[cur] >= r_ltime[r_best])) begin
                            n_best = cur;
                            n_have = 1'b1;
                        end
                    end
                end
                if (last) begin
                    if (!r_lost) begin
                        n_winner = n_best;
                    end
                end else begin
                    n_idx = r_idx + (SW+1)'(1);
                end
            end
            ST_RDREQ: ;
            ST_RDWAIT: begin
                // Memory byte for slot cur is ready now.
                if (use_max && r_live[cur] && is_top &&
                    (32'(r_cmd.channel) < lim) && (mem_rdata > r_acc)) begin
                    n_acc = mem_rdata;
                end
                if (!use_max && (cur == r_winner)) begin
                    n_acc = mem_rdata;
                end
                if (!last) begin
                    n_idx = r_idx + (SW+1)'(1);
                end
            end
            ST_OUT: begin
                // Load the result once the output register is free.
                if (!r_obuf_v || i_ready) begin
                    n_obuf_v = 1'b1;
                    n_obuf.source_lost       = r_lost;
                    n_obuf.loss_count        = r_loss_cnt;
                    n_obuf.contributor_count = 4'(live_cnt);
                    n_obuf.loss_action       = ActNone;
                    n_obuf.channel_value     = '0;
                    n_obuf.channel_written   = 1'b0;
                    if (r_cmd.command == CMD_EVAL) begin
                        n_obuf.loss_action = r_action;
                    end else if (32'(r_cmd.channel) < 32'(CHANNELS)) begin
                        if (r_lost) begin
                            n_obuf.channel_written = (r_loss_mode == LossZero);
                        end else if (r_live != '0) begin
                            if (r_merge_mode == MM_PRIO_MAX) begin
                                if (32'(r_cmd.channel) < 32'(PRIORITY_CHANNELS)) begin
                                    n_obuf.channel_written = 1'b1;
                                    n_obuf.channel_value   = r_acc;
                                end
                            end else if (use_max) begin
                                n_obuf.channel_written = 1'b1;
                                n_obuf.channel_value   = r_acc;
                            end else if (32'(r_cmd.channel) <
                                         ((32'(r_len[r_winner]) > 32'(CHANNELS)) ?
                                          32'(CHANNELS) : 32'(r_len[r_winner]))) begin
                                n_obuf.channel_written = 1'b1;
                                n_obuf.channel_value   = r_acc;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_idx      <= '0;
            r_live     <= '0;
            r_top      <= '0;
            r_winner   <= '0;
            r_lost     <= 1'b0;
            r_loss_cnt <= '0;
            r_have     <= 1'b0;
            r_best     <= '0;
            r_acc      <= '0;
            r_action   <= ActNone;
            r_obuf_v   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_live     <= n_live;
            r_top      <= n_top;
            r_winner   <= n_winner;
            r_lost     <= n_lost;
            r_loss_cnt <= n_loss_cnt;
            r_have     <= n_have;
            r_best     <= n_best;
            r_acc      <= n_acc;
            r_action   <= n_action;
            r_obuf_v   <= n_obuf_v;
        end
        r_obuf <= n_obuf;
    end

    // A loss flag and a live sender never stand together after evaluate.
    a_lost_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) && r_lost |-> (r_live == '0))
        else $error("loss flag set with live senders");

    // The loss counter moves only on entry into loss.
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_loss_cnt != $past(r_loss_cnt)) |-> (r_lost && !$past(r_lost)))
        else $error("loss counter moved without loss entry");

    // A result word that the receiver stalls stays valid and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_obuf_v && !i_ready |=> r_obuf_v && $stable(r_obuf))
        else $error("stalled result word changed");
endmodule

FILE: hdl/dmx_chan_mem.sv
module dmx_chan_mem #(
    parameter int SLOTS = 8,
    parameter int CHANS = 512
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [$clog2(SLOTS*CHANS)-1:0]       i_waddr,
    input  logic [7:0]                           i_wdata,
    input  logic [$clog2(SLOTS*CHANS)-1:0]       i_raddr,
    output logic [7:0]                           o_rdata
);
    localparam int Depth = SLOTS * CHANS;

    logic [7:0] r_mem [Depth];

    // Byte store for all sender channels, registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
